// File: rtl/core/ilf_pkg.sv
`default_nettype none
package ilf_pkg;
  localparam int OpcodeBits = 2;
  localparam int IndexBits  = 8;
  localparam int StatusBits = 2;

  localparam logic [OpcodeBits-1:0] OP_WRITE_GOOD = 2'd0;
  localparam logic [OpcodeBits-1:0] OP_WRITE_CUT  = 2'd1;
  localparam logic [OpcodeBits-1:0] OP_QUERY      = 2'd2;

  localparam logic [StatusBits-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [StatusBits-1:0] ST_REJECTED = 2'd1;
  localparam logic [StatusBits-1:0] ST_ORDER    = 2'd2;

  localparam int CfgIndexBits = 1;
  localparam int CfgDataBits  = 9;
  localparam logic [CfgIndexBits-1:0] REG_GOOD_COUNT = 1'd0;
  localparam logic [CfgIndexBits-1:0] REG_CUT_COUNT  = 1'd1;
endpackage
`default_nettype wire

// File: rtl/core/ilf_if.sv
`default_nettype none
interface ilf_in_if #(parameter int TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [7:0]           entry_index;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] stop_time;
  modport source (output valid, opcode, entry_index, start_time, stop_time, input ready);
  modport sink (input valid, opcode, entry_index, start_time, stop_time, output ready);
endinterface

interface ilf_out_if #(parameter int FRACTION_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [FRACTION_BITS:0] live_fraction;
  modport source (output valid, status, live_fraction, input ready);
  modport sink (input valid, status, live_fraction, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ilf_ram.sv
`default_nettype none
module ilf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/interval_livetime_fraction_unit.sv
`default_nettype none
// A query scans the cut table, then the good table, through the shared intersect unit,
// then divides one quotient bit per cycle; a zero-length or reversed query skips to the
// result, a cut that misses ends the scan, and a fully covered span ends the divide.
// Good entries are read one per cycle; each cut entry takes a wait state and a check state.
// Throughput: writes transfer every cycle while idle; after a query transfer the input is held off
// until its result transfers. Reset (synchronous, rst_n low) clears counts and control only.
module interval_livetime_fraction_unit
  import ilf_pkg::*;
#(
  parameter int GOOD_DEPTH    = 256,
  parameter int CUT_DEPTH     = 8,
  parameter int TIME_BITS     = 48,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CfgIndexBits-1:0] cfg_index,
  input  wire logic [CfgDataBits-1:0]  cfg_data,
  ilf_in_if.sink                       in_ch,
  ilf_out_if.source                    out_ch
);
  localparam int GA = (GOOD_DEPTH > 1) ? $clog2(GOOD_DEPTH) : 1;
  localparam int CA = (CUT_DEPTH > 1) ? $clog2(CUT_DEPTH) : 1;
  localparam int GC = $clog2(GOOD_DEPTH + 1);
  localparam int CC = $clog2(CUT_DEPTH + 1);
  localparam int FC = $clog2(FRACTION_BITS + 1);
  localparam int TB = TIME_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CUT  = 3'd1;
  localparam logic [2:0] S_CUTW = 3'd2;
  localparam logic [2:0] S_GOOD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [GC-1:0] good_cnt_r;
  logic [CC-1:0] cut_cnt_r;
  logic [TB-1:0] lo_r, hi_r, span_r, total_r, den_r, rem_r;
  logic [GC:0]   idx_r;
  logic [FC-1:0] bit_r;
  logic [FRACTION_BITS:0] q_r;
  logic [1:0]    status_r;
  logic          out_valid_r;

  // configuration, saturated to table depth (cut count taken from cfg_data[3:0])
  logic [CfgDataBits-1:0] gsat, csat;
  always_comb begin
    gsat = (cfg_data > CfgDataBits'(GOOD_DEPTH)) ? CfgDataBits'(GOOD_DEPTH) : cfg_data;
    csat = ({5'd0, cfg_data[3:0]} > CfgDataBits'(CUT_DEPTH)) ? CfgDataBits'(CUT_DEPTH)
           : {5'd0, cfg_data[3:0]};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_cnt_r <= '0;
      cut_cnt_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOOD_COUNT: good_cnt_r <= GC'(gsat);
        REG_CUT_COUNT:  cut_cnt_r  <= CC'(csat);
        default: ;
      endcase
    end
  end

  wire acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  // table memories
  logic [2*TB-1:0] good_rd, cut_rd;
  logic [GA-1:0]   good_ra;
  logic [CA-1:0]   cut_ra;
  wire good_we = acc && in_ch.opcode == OP_WRITE_GOOD &&
                 {1'b0, in_ch.entry_index} < 9'(GOOD_DEPTH);
  wire cut_we  = acc && in_ch.opcode == OP_WRITE_CUT &&
                 {1'b0, in_ch.entry_index} < 9'(CUT_DEPTH);
  // hold address 0 ahead of the good scan so its first cycle sees entry 0
  assign good_ra = (state_r == S_GOOD) ? GA'(idx_r) : '0;
  assign cut_ra  = CA'(idx_r >> 1);

  ilf_ram #(.WIDTH(2*TB), .DEPTH(GOOD_DEPTH)) u_good (
    .clk, .we(good_we), .waddr(GA'(in_ch.entry_index)),
    .wdata({in_ch.start_time, in_ch.stop_time}), .raddr(good_ra), .rdata(good_rd));
  ilf_ram #(.WIDTH(2*TB), .DEPTH(CUT_DEPTH)) u_cut (
    .clk, .we(cut_we), .waddr(CA'(in_ch.entry_index)),
    .wdata({in_ch.start_time, in_ch.stop_time}), .raddr(cut_ra), .rdata(cut_rd));

  // shared intersect unit
  logic [TB-1:0] ent_a, ent_b, ia, ib, dt, room;
  logic          hit;
  always_comb begin
    ent_a = (state_r == S_CUT) ? cut_rd[2*TB-1:TB] : good_rd[2*TB-1:TB];
    ent_b = (state_r == S_CUT) ? cut_rd[TB-1:0] : good_rd[TB-1:0];
    ia    = (ent_a > lo_r) ? ent_a : lo_r;
    ib    = (ent_b < hi_r) ? ent_b : hi_r;
    hit   = ia < ib;
    dt    = ib - ia;
    room  = span_r - total_r;
  end

  // restoring-style divide step: r vs den - r
  logic [TB-1:0] gap;
  assign gap = den_r - rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == S_OUT) out_valid_r <= 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc && in_ch.opcode == OP_QUERY) begin
        if (in_ch.stop_time <= in_ch.start_time) state_nxt = S_OUT;
        else if (cut_cnt_r != '0) state_nxt = S_CUTW;
        else state_nxt = (good_cnt_r != '0) ? S_GOOD : S_DIV;
      end
      S_CUTW: state_nxt = S_CUT;
      S_CUT: begin
        if (!hit) state_nxt = S_OUT;
        else if (idx_r[GC:1] + 1'b1 == (GC)'(cut_cnt_r))
          state_nxt = (good_cnt_r != '0) ? S_GOOD : S_DIV;
        else state_nxt = S_CUTW;
      end
      S_GOOD: if (idx_r == {1'b0, good_cnt_r}) state_nxt = S_DIV;
      S_DIV:  if (bit_r == FC'(FRACTION_BITS)) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath; idx_r counts half-steps in the cut scan, read addresses in the good scan
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (acc) begin
        lo_r     <= in_ch.start_time;
        hi_r     <= in_ch.stop_time;
        den_r    <= in_ch.stop_time - in_ch.start_time;
        span_r   <= in_ch.stop_time - in_ch.start_time;
        total_r  <= (good_cnt_r == '0) ? in_ch.stop_time - in_ch.start_time : '0;
        status_r <= (in_ch.stop_time < in_ch.start_time) ? ST_ORDER : ST_REJECTED;
        idx_r    <= (cut_cnt_r == '0 && in_ch.stop_time > in_ch.start_time) ?
                    (GC+1)'(1) : '0;
      end
      S_CUTW: idx_r <= idx_r + 1'b1;
      S_CUT: begin
        lo_r   <= ia;
        hi_r   <= ib;
        span_r <= dt;
        if (good_cnt_r == '0) total_r <= dt;
        if (idx_r[GC:1] + 1'b1 == (GC)'(cut_cnt_r)) idx_r <= (GC+1)'(1);
        else idx_r <= idx_r + 1'b1;
      end
      S_GOOD: begin
        // data present is for entry idx_r-1
        if (hit) total_r <= (dt >= room) ? span_r : total_r + dt;
        idx_r <= idx_r + 1'b1;
      end
      default: ;
    endcase
    if (state_r != S_DIV && state_nxt == S_DIV) begin
      bit_r <= '0;
      q_r   <= '0;
    end
    if (state_r == S_DIV && bit_r != FC'(FRACTION_BITS)) begin
      if (bit_r == '0 && rem_r >= den_r) begin
        q_r   <= (FRACTION_BITS+1)'(1) << FRACTION_BITS;
        bit_r <= FC'(FRACTION_BITS);
      end else begin
        bit_r <= bit_r + 1'b1;
        if (rem_r >= gap) begin
          rem_r <= rem_r - gap;
          q_r   <= {q_r[FRACTION_BITS-1:0], 1'b1};
        end else begin
          rem_r <= rem_r + rem_r;
          q_r   <= {q_r[FRACTION_BITS-1:0], 1'b0};
        end
      end
    end else if (state_r != S_DIV && state_nxt == S_DIV) begin
      rem_r <= (state_r == S_IDLE) ? in_ch.stop_time - in_ch.start_time
             : (state_r == S_GOOD && hit) ? ((dt >= room) ? span_r : total_r + dt)
             : (state_r == S_CUT && good_cnt_r == '0) ? dt : total_r;
    end
    if (state_r == S_DIV && state_nxt == S_OUT) status_r <= ST_ACCEPTED;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.live_fraction = (status_r == ST_ACCEPTED) ? q_r : '0;
endmodule
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ilf_pkg::*;

  localparam int TB = 48;
  localparam int FB = 16;
  localparam int GOOD_SLOTS = 256;
  localparam int CUT_SLOTS = 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;
  localparam int LONG_HOLD = 600;

  typedef logic [TB-1:0] stamp_t;
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    stamp_t     t0;
    stamp_t     t1;
  } req_t;
  typedef struct packed {
    logic [1:0]  status;
    logic [FB:0] frac;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [CfgDataBits-1:0] cfg_data;

  ilf_in_if #(.TIME_BITS(TB)) in_bus ();
  ilf_out_if #(.FRACTION_BITS(FB)) out_bus ();

  interval_livetime_fraction_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_bus.sink),
    .out_ch   (out_bus.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // local copy of the block's tables and counts
  stamp_t good_lo [GOOD_SLOTS];
  stamp_t good_hi [GOOD_SLOTS];
  stamp_t cut_lo [CUT_SLOTS];
  stamp_t cut_hi [CUT_SLOTS];
  int good_in_use = 0;
  int cut_in_use = 0;

  req_t pending_reqs[$];
  verdict_t expected_verdicts[$];
  req_t cur_req;
  int send_gap, recv_gap, hold_left;
  bit quiet = 0;
  bit hold_req = 0, hold_ack = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic verdict_t query_verdict(stamp_t t0, stamp_t t1);
    verdict_t v;
    stamp_t lo, hi, a, b, span, total;
    logic [79:0] scaled;
    v.status = ST_REJECTED;
    v.frac = '0;
    if (t1 < t0) begin
      v.status = ST_ORDER;
      return v;
    end
    if (t0 == t1) return v;
    lo = t0;
    hi = t1;
    for (int i = 0; i < cut_in_use; i++) begin
      a = (cut_lo[i] > lo) ? cut_lo[i] : lo;
      b = (cut_hi[i] < hi) ? cut_hi[i] : hi;
      if (a >= b) return v;
      lo = a;
      hi = b;
    end
    span = hi - lo;
    total = (good_in_use == 0) ? span : '0;
    for (int i = 0; i < good_in_use; i++) begin
      a = (good_lo[i] > lo) ? good_lo[i] : lo;
      b = (good_hi[i] < hi) ? good_hi[i] : hi;
      if (a < b) begin
        if (b - a >= span - total) total = span;
        else total = total + (b - a);
      end
    end
    v.status = ST_ACCEPTED;
    if (total >= t1 - t0) begin
      v.frac = (FB+1)'(1) << FB;
    end else begin
      scaled = {32'b0, total} << FB;
      v.frac = (FB+1)'(scaled / {32'b0, stamp_t'(t1 - t0)});
    end
    return v;
  endfunction

  function automatic void take_transfer(req_t r);
    case (r.op)
      OP_WRITE_GOOD: begin
        good_lo[r.idx] = r.t0;
        good_hi[r.idx] = r.t1;
      end
      OP_WRITE_CUT: begin
        if (r.idx < CUT_SLOTS) begin
          cut_lo[r.idx] = r.t0;
          cut_hi[r.idx] = r.t1;
        end
      end
      OP_QUERY: expected_verdicts.insert(expected_verdicts.size(), query_verdict(r.t0, r.t1));
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(string what, verdict_t want, verdict_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected status %0d fraction %0d, got status %0d fraction %0d",
               what, want.status, want.frac, got.status, got.frac);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) take_transfer(cur_req);
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 5) != 0)) begin
          cur_req = pending_reqs.pop_front();
          in_bus.opcode <= cur_req.op;
          in_bus.entry_index <= cur_req.idx;
          in_bus.start_time <= cur_req.t0;
          in_bus.stop_time <= cur_req.t1;
          in_bus.valid <= 1'b1;
        end else begin
          if (pending_reqs.size() > 0) send_gap <= $urandom_range(0, 7);
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.status = out_bus.status;
        got.frac = out_bus.live_fraction;
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.status !== want.status) flag_mismatch("status", want, got);
          else if (got.frac !== want.frac) flag_mismatch("live_fraction", want, got);
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= LONG_HOLD;
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] op, logic [7:0] idx, stamp_t t0, stamp_t t1);
    req_t r;
    r.op = op;
    r.idx = idx;
    r.t0 = t0;
    r.t1 = t1;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_bus.valid || expected_verdicts.size() != 0);
    // writes leave no result, so give the last one time to land
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexBits-1:0] idx, int value);
    int v;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CfgDataBits-1:0];
    v = value & ((1 << CfgDataBits) - 1);
    if (idx == REG_GOOD_COUNT) good_in_use = (v > GOOD_SLOTS) ? GOOD_SLOTS : v;
    else cut_in_use = ((v & 15) > CUT_SLOTS) ? CUT_SLOTS : (v & 15);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic stamp_t rand_stamp();
    return {$urandom, $urandom};
  endfunction

  initial begin
    longint unsigned scale, base, t, q0, qlen;
    stamp_t s0, s1;
    int items, gn, cn, nq, nk, r, phase;
    in_bus.valid = 1'b0;
    in_bus.opcode = '0;
    in_bus.entry_index = '0;
    in_bus.start_time = '0;
    in_bus.stop_time = '0;
    out_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // fill every slot so no query ever reads an unwritten entry
    for (int i = 0; i < GOOD_SLOTS; i++)
      push_req(OP_WRITE_GOOD, i, (i << 20) + (1 << 18), (i << 20) + (3 << 18));
    for (int i = 0; i < CUT_SLOTS; i++) push_req(OP_WRITE_CUT, i, '0, '1);
    wait_idle();
    write_reg(REG_GOOD_COUNT, 0);
    write_reg(REG_CUT_COUNT, 0);
    push_req(OP_QUERY, 0, '0, '1);
    push_req(OP_QUERY, 0, '1, '0);
    push_req(OP_QUERY, 0, 5, 5);
    push_req(OP_QUERY, 0, 0, 1);
    wait_idle();
    write_reg(REG_GOOD_COUNT, GOOD_SLOTS);
    write_reg(REG_CUT_COUNT, CUT_SLOTS);
    push_req(OP_QUERY, 0, '0, 1 << 28);
    push_req(OP_QUERY, 0, 1 << 18, 3 << 18);
    push_req(OP_QUERY, 0, '0, '1);
    push_req(OP_WRITE_CUT, 2, 1 << 30, 1 << 31);
    push_req(OP_QUERY, 0, '0, 1 << 20);
    push_req(OP_QUERY, 0, '0, '1);
    push_req(2'd3, 8'hff, '1, '1);
    push_req(OP_WRITE_CUT, 200, 5, 6);
    push_req(OP_WRITE_GOOD, 0, 1 << 31, 1 << 30);
    push_req(OP_WRITE_GOOD, 1, '0, '1);
    push_req(OP_QUERY, 0, 1 << 29, 3 << 30);
    wait_idle();
    write_reg(REG_GOOD_COUNT, 511);
    write_reg(REG_CUT_COUNT, 15);
    push_req(OP_QUERY, 0, (1 << 30) + 7, (1 << 31) - 3);
    push_req(OP_WRITE_CUT, 2, '0, '1);
    push_req(OP_QUERY, 0, 12345, 1 << 40);
    wait_idle();

    phase = 0;
    while (items < 500) begin
      phase++;
      if (items > 420) quiet = 1;
      r = $urandom_range(0, 9);
      gn = (r < 6) ? $urandom_range(0, 12) : (r < 8) ? GOOD_SLOTS : $urandom_range(257, 511);
      r = $urandom_range(0, 9);
      cn = (r < 3) ? 0 : (r < 8) ? $urandom_range(1, CUT_SLOTS) : 15;
      write_reg(REG_GOOD_COUNT, gn);
      write_reg(REG_CUT_COUNT, cn);
      scale = 64'd1 << $urandom_range(0, 26);
      r = $urandom_range(0, 3);
      base = (r == 0) ? 0 : (r == 1) ? (64'd1 << 48) - (scale << 9) : (rand_stamp() >> 1);

      // sorted good intervals near base, with some reversed or overlapping
      t = base;
      nk = (gn < 40) ? gn : 40;
      for (int i = 0; i < nk; i++) begin
        t += $urandom_range(0, 3) * scale;
        s0 = t;
        t += $urandom_range(1, 4) * scale;
        s1 = t;
        r = $urandom_range(0, 15);
        if (r == 0) push_req(OP_WRITE_GOOD, i, s1, s0);
        else if (r == 1) push_req(OP_WRITE_GOOD, i, s0 - 2 * scale, s1);
        else push_req(OP_WRITE_GOOD, i, s0, s1);
        items++;
      end
      t += scale;
      for (int i = 0; i < CUT_SLOTS; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_req(OP_WRITE_CUT, i, rand_stamp(), rand_stamp());
        end else begin
          push_req(OP_WRITE_CUT, i, base + $urandom_range(0, 2) * scale,
                   t - $urandom_range(0, 2) * scale);
        end
        items++;
      end

      nq = $urandom_range(10, 30);
      for (int k = 0; k < nq; k++) begin
        r = $urandom_range(0, 15);
        q0 = base + $urandom_range(0, 4 * nk + 2) * scale + $urandom_range(0, 255);
        qlen = $urandom_range(0, 8) * scale + $urandom_range(0, 1023);
        case (r)
          0: push_req(OP_QUERY, 0, q0 + qlen + 1, q0);
          1: push_req(OP_QUERY, 0, q0, q0);
          2: push_req(OP_QUERY, 0, rand_stamp(), rand_stamp());
          3: push_req(2'd3, $urandom_range(0, 255), rand_stamp(), rand_stamp());
          4: push_req(OP_WRITE_CUT, $urandom_range(CUT_SLOTS, 255), rand_stamp(), rand_stamp());
          default: push_req(OP_QUERY, 0, q0, q0 + qlen + 1);
        endcase
        if (r != 3 && r != 4) items++;
      end
      // hold off the result side while the sender keeps offering queries
      if (phase == 3 || phase == 9) hold_req = ~hold_req;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
